### hdl/las_pkg.sv
// Shared types and constants for the life automaton stencil.
// Used by las_stencil and the top level; depends on nothing.

package las_pkg;

    // Line store depth bounds the widest row the block can hold.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_WIDTH  = 4;
    localparam int MIN_HEIGHT = 3;

    // Register field widths.
    localparam int GRID_WIDTH_W  = 11;
    localparam int GRID_HEIGHT_W = 13;
    localparam int MASK_W        = 9;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 2;

    // Derived counter widths.
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int USED_W_W = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W   = (USED_W_W > GRID_WIDTH_W) ? USED_W_W : GRID_WIDTH_W;
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int USED_H_W = $clog2(MAX_HEIGHT + 1);
    localparam int HCMP_W   = (USED_H_W > GRID_HEIGHT_W) ? USED_H_W : GRID_HEIGHT_W;
    localparam int COUNT_W  = $clog2(MASK_W);

    // Reset values of the configuration registers.
    localparam logic [GRID_WIDTH_W-1:0]  RST_GRID_WIDTH  = GRID_WIDTH_W'(1024);
    localparam logic [GRID_HEIGHT_W-1:0] RST_GRID_HEIGHT = GRID_HEIGHT_W'(1024);
    localparam logic [MASK_W-1:0]        RST_BIRTH_MASK  = MASK_W'(12);
    localparam logic [MASK_W-1:0]        RST_SURVIVE_MASK = MASK_W'(12);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH   = 2'd0,
        REG_GRID_HEIGHT  = 2'd1,
        REG_BIRTH_MASK   = 2'd2,
        REG_SURVIVE_MASK = 2'd3
    } t_reg_index;

    // One request as it moves from the accept stage into the stencil stage.
    typedef struct packed {
        logic             do_cell;   // touches line store and window
        logic             emit;      // produces a result
        logic             interior;  // window centre is an interior cell
        logic             last;      // result closes the frame
        logic             alive;     // arriving cell state
        logic [COL_W-1:0] col;       // column of the arriving cell
    } t_stage;

endpackage

### hdl/life_automaton_stencil_top.sv
// Life automaton stencil: one generation of a two-state automaton over a
// row-major cell stream. A request passes two register stages (stage and
// output registers); its result belongs to the cell grid_width+1 places
// back. Throughput: one request per cycle unless the output stalls, set by the
// single line-store port pair. Synchronous active-low reset clears counters,
// window and output; line stores are kept. Depends on las_pkg, las_stencil.

module life_automaton_stencil_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [las_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [las_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Request stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [0] cell_alive, [7:1] zero
    input  logic [0:0]                        s_axis_tuser,  // [0] op
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // [0] next_alive, [7:1] zero
    output logic                              m_axis_tlast   // frame_last
);

    logic [las_pkg::GRID_WIDTH_W-1:0]  r_grid_width;
    logic [las_pkg::GRID_HEIGHT_W-1:0] r_grid_height;
    logic [las_pkg::MASK_W-1:0]        r_birth_mask;
    logic [las_pkg::MASK_W-1:0]        r_survive_mask;

    logic [las_pkg::USED_W_W-1:0] w_used;
    logic [las_pkg::USED_H_W-1:0] h_used;
    logic [las_pkg::WCMP_W-1:0]   w_ext;
    logic [las_pkg::HCMP_W-1:0]   h_ext;

    logic [las_pkg::COL_W-1:0]    r_col, n_col;
    logic [las_pkg::ROW_W-1:0]    r_row, n_row;
    logic [las_pkg::USED_W_W-1:0] r_drain, n_drain;
    logic                         r_arrived, n_arrived;

    logic            r_s1_valid, n_s1_valid;
    las_pkg::t_stage r_s1, n_s1;

    logic r_out_valid;
    logic r_out_alive;
    logic r_out_last;

    logic en;
    logic acc;
    logic geom_write;
    logic step;
    logic next_alive;

    // Width and height are used clamped to their legal ranges.
    always_comb begin
        w_ext = las_pkg::WCMP_W'(r_grid_width);
        if (w_ext < las_pkg::WCMP_W'(las_pkg::MIN_WIDTH)) begin
            w_ext = las_pkg::WCMP_W'(las_pkg::MIN_WIDTH);
        end else if (w_ext > las_pkg::WCMP_W'(las_pkg::MAX_WIDTH)) begin
            w_ext = las_pkg::WCMP_W'(las_pkg::MAX_WIDTH);
        end
        w_used = las_pkg::USED_W_W'(w_ext);
        h_ext = las_pkg::HCMP_W'(r_grid_height);
        if (h_ext < las_pkg::HCMP_W'(las_pkg::MIN_HEIGHT)) begin
            h_ext = las_pkg::HCMP_W'(las_pkg::MIN_HEIGHT);
        end else if (h_ext > las_pkg::HCMP_W'(las_pkg::MAX_HEIGHT)) begin
            h_ext = las_pkg::HCMP_W'(las_pkg::MAX_HEIGHT);
        end
        h_used = las_pkg::USED_H_W'(h_ext);
    end

    assign en            = !r_out_valid || m_axis_tready;
    assign acc           = s_axis_tvalid && en;
    assign s_axis_tready = en;
    assign step          = r_s1_valid && en && r_s1.do_cell;
    assign geom_write    = i_cfg_we &&
                           ((i_cfg_index == las_pkg::REG_GRID_WIDTH) ||
                            (i_cfg_index == las_pkg::REG_GRID_HEIGHT));

    // Accept stage: position counters and the request sent to the stencil.
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_drain    = r_drain;
        n_arrived  = r_arrived;
        n_s1_valid = 1'b0;
        n_s1       = '0;
        n_s1.col   = r_col;
        n_s1.alive = s_axis_tdata[0];
        if (acc) begin
            if (r_arrived) begin
                // Tail of the frame: every request yields an edge result.
                n_s1_valid = 1'b1;
                n_s1.emit  = 1'b1;
                n_s1.last  = (r_drain == w_used);
                if (n_s1.last) begin
                    n_col     = '0;
                    n_row     = '0;
                    n_drain   = '0;
                    n_arrived = 1'b0;
                end else begin
                    n_drain = r_drain + 1'b1;
                end
            end else if (!s_axis_tuser[0]) begin
                n_s1_valid    = 1'b1;
                n_s1.do_cell  = 1'b1;
                n_s1.emit     = (r_row >= las_pkg::ROW_W'(2)) ||
                                ((r_row == las_pkg::ROW_W'(1)) && (r_col != '0));
                n_s1.interior = (r_row >= las_pkg::ROW_W'(2)) &&
                                (r_col >= las_pkg::COL_W'(2));
                if (las_pkg::USED_W_W'(r_col) == w_used - 1'b1) begin
                    n_col = '0;
                    if (las_pkg::USED_H_W'(r_row) == h_used - 1'b1) begin
                        n_row     = '0;
                        n_arrived = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
        if (geom_write) begin
            n_col     = '0;
            n_row     = '0;
            n_drain   = '0;
            n_arrived = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width   <= las_pkg::RST_GRID_WIDTH;
            r_grid_height  <= las_pkg::RST_GRID_HEIGHT;
            r_birth_mask   <= las_pkg::RST_BIRTH_MASK;
            r_survive_mask <= las_pkg::RST_SURVIVE_MASK;
        end else if (i_cfg_we) begin
            unique case (las_pkg::t_reg_index'(i_cfg_index))
                las_pkg::REG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[las_pkg::GRID_WIDTH_W-1:0];
                end
                las_pkg::REG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[las_pkg::GRID_HEIGHT_W-1:0];
                end
                las_pkg::REG_BIRTH_MASK: begin
                    r_birth_mask <= i_cfg_data[las_pkg::MASK_W-1:0];
                end
                las_pkg::REG_SURVIVE_MASK: begin
                    r_survive_mask <= i_cfg_data[las_pkg::MASK_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_drain     <= '0;
            r_arrived   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_drain   <= n_drain;
            r_arrived <= n_arrived;
            if (en) begin
                r_s1_valid  <= n_s1_valid;
                r_out_valid <= r_s1_valid && r_s1.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1        <= n_s1;
            r_out_alive <= next_alive;
            r_out_last  <= r_s1.last;
        end
    end

    las_stencil u_stencil (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd_en        (acc && n_s1.do_cell),
        .i_rd_addr      (r_col),
        .i_step         (step),
        .i_stage        (r_s1),
        .i_clear        (geom_write || (r_s1_valid && en && r_s1.last)),
        .i_birth_mask   (r_birth_mask),
        .i_survive_mask (r_survive_mask),
        .o_next_alive   (next_alive)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_alive};
    assign m_axis_tlast  = r_out_last;

endmodule

### hdl/las_stencil.sv
// Stencil stage: the two line stores in one 2-bit-wide memory, the 3x3 window
// and the birth/survive rule. Depends on las_pkg.

module las_stencil (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [las_pkg::COL_W-1:0]    i_rd_addr,
    input  logic                         i_step,
    input  las_pkg::t_stage              i_stage,
    input  logic                         i_clear,
    input  logic [las_pkg::MASK_W-1:0]   i_birth_mask,
    input  logic [las_pkg::MASK_W-1:0]   i_survive_mask,
    output logic                         o_next_alive
);

    // Bit 0 holds the row two above the arriving one, bit 1 the row just above.
    logic [1:0] r_line [las_pkg::MAX_WIDTH];
    logic [1:0] r_rd;
    logic [8:0] r_window;
    logic [8:0] n_window;
    logic [las_pkg::COUNT_W-1:0] neighbor_count;
    logic [las_pkg::MASK_W-1:0]  rule_mask;

    // Read is issued when the request is accepted; the data is used while that
    // request sits in the stage register. The same column comes back only a full
    // row later, so the write below never races a read of the same entry.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_line[i_rd_addr];
        end
        if (i_step) begin
            r_line[i_stage.col] <= {i_stage.alive, r_rd[1]};
        end
    end

    always_comb begin
        n_window = {i_stage.alive, r_rd[1], r_rd[0], r_window[8:3]};
        neighbor_count = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                neighbor_count = neighbor_count + las_pkg::COUNT_W'(n_window[k]);
            end
        end
        rule_mask = n_window[4] ? i_survive_mask : i_birth_mask;
        o_next_alive = i_stage.do_cell && i_stage.interior && rule_mask[neighbor_count];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (i_clear) begin
            r_window <= '0;
        end else if (i_step) begin
            r_window <= n_window;
        end
    end

endmodule

### hdl/las_check.sv
// Port-level checks for life_automaton_stencil_top, attached by bind.
// Depends only on the top level's ports.

module las_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [7:0]                        m_axis_tdata,
    input logic                              m_axis_tlast
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // The input side only waits while a result is blocked.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A new result follows an accepted request.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without matching request");

    // The last cell of a frame is an edge cell and is always dead.
    a_last_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[0] == 1'b0)
        else $error("frame end result alive");

endmodule

bind life_automaton_stencil_top las_check u_las_check (.*);
